### src/stl_pkg.sv
`default_nettype none
package stl_pkg;

  // lexer modes
  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_COMMENT = 4'd1;
  localparam logic [3:0] MODE_STRING  = 4'd2;
  localparam logic [3:0] MODE_ESCAPE  = 4'd3;
  localparam logic [3:0] MODE_CONST   = 4'd4;
  localparam logic [3:0] MODE_NUMBER  = 4'd5;
  localparam logic [3:0] MODE_SYMBOL  = 4'd6;
  localparam logic [3:0] MODE_DONE    = 4'd7;
  localparam logic [3:0] MODE_ERROR   = 4'd8;

  // result kinds
  localparam logic [1:0] RK_BYTE = 2'd0;
  localparam logic [1:0] RK_END  = 2'd1;
  localparam logic [1:0] RK_ERR  = 2'd2;

  // token kinds
  localparam logic [3:0] TK_OPEN    = 4'd0;
  localparam logic [3:0] TK_CLOSE   = 4'd1;
  localparam logic [3:0] TK_STRING  = 4'd2;
  localparam logic [3:0] TK_TRUE    = 4'd3;
  localparam logic [3:0] TK_FALSE   = 4'd4;
  localparam logic [3:0] TK_EOF     = 4'd5;
  localparam logic [3:0] TK_SYMBOL  = 4'd6;
  localparam logic [3:0] TK_REAL    = 4'd7;
  localparam logic [3:0] TK_INTEGER = 4'd8;

  // error codes
  localparam logic EC_STRING = 1'b0;
  localparam logic EC_CONST  = 1'b1;

  // characters
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [3:0]  tk;
    logic        ec;
    logic [23:0] line;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
           || (c == CH_UNDER);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_QUOTE) || (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_SEMI);
  endfunction

  function automatic res_t mk_byte(input logic [7:0] c);
    res_t r;
    r = '0;
    r.kind = RK_BYTE;
    r.ch = c;
    return r;
  endfunction

  function automatic res_t mk_end(input logic [3:0] tk);
    res_t r;
    r = '0;
    r.kind = RK_END;
    r.tk = tk;
    return r;
  endfunction

  function automatic res_t mk_err(input logic ec, input logic [23:0] line);
    res_t r;
    r = '0;
    r.kind = RK_ERR;
    r.ec = ec;
    r.line = line;
    return r;
  endfunction

endpackage
`default_nettype wire

### src/sexpr_token_lexer.sv
`default_nettype none
// path: a byte accepted at a clock edge is written into the queue at that edge;
//   the back stage then loads the entry into its output register and offers it
// throughput: one byte per cycle while the queue is not full; a byte that causes
//   two results gives two output beats, and the two-entry queue between the lexer
//   front and the output stage absorbs that while it has room
// reset: synchronous, active low; clears lexer state, line count and queue
module sexpr_token_lexer #(
  parameter int MAX_TOKEN = 1024,
  localparam int LEN_W = $clog2(MAX_TOKEN + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end_of_input,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_res_kind,
  output logic [7:0]            out_char_value,
  output logic [3:0]            out_token_kind,
  output logic [LEN_W-1:0]      out_stored_length,
  output logic                  out_error_code,
  output logic [23:0]           out_error_line,
  output logic                  out_last
);
  import stl_pkg::*;

  // one queue entry: up to two results plus their lengths and a pair flag
  localparam int EW = 2 * RES_W + 2 * LEN_W + 1;

  logic          push, pop;
  logic [EW-1:0] push_data, pop_data;
  fifo_stat_t    stat;

  // front: mode tracking, classification, per-byte result generation
  stl_front #(.MAX_TOKEN(MAX_TOKEN), .LEN_W(LEN_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_end    (in_end_of_input),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  stl_fifo #(.DW(EW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  // back: serializes each entry into one or two result beats
  stl_back #(.LEN_W(LEN_W)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .stat              (stat),
    .pop_data          (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_res_kind      (out_res_kind),
    .out_char_value    (out_char_value),
    .out_token_kind    (out_token_kind),
    .out_stored_length (out_stored_length),
    .out_error_code    (out_error_code),
    .out_error_line    (out_error_line),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire

### src/stl_front.sv
`default_nettype none
module stl_front #(
  parameter int MAX_TOKEN = 1024,
  parameter int LEN_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end,
  input  wire stl_pkg::fifo_stat_t stat,
  output logic                  push,
  output logic [2*stl_pkg::RES_W+2*LEN_W:0] push_data
);
  import stl_pkg::*;

  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_TOKEN);

  logic [3:0]       mode_r, mode_nxt, i_mode;
  logic [LEN_W-1:0] cnt_r, cnt_nxt, i_cnt;
  logic [23:0]      line_r, line_nxt;
  logic [23:0]      sline_r, sline_nxt, i_sline;
  logic             dig_r, dig_nxt, i_dig;
  logic             nd_r, nd_nxt;
  logic [1:0]       dot_r, dot_nxt;
  logic [7:0]       first_r, first_nxt, i_first;
  logic             i_v, v0, v1, acc, term;
  res_t             i_res, r0, r1;
  logic [LEN_W-1:0] l0, l1;
  logic [7:0]       c, sb;
  logic [3:0]       num_tk;

  assign c = in_byte;
  assign in_ready = !stat.full;
  assign acc = in_valid && in_ready;
  assign term = is_space(c) || is_delim(c);

  always_comb begin
    line_nxt = line_r;
    if (!in_end && c == CH_LF && mode_r != MODE_ERROR && line_r != LINE_MAX) begin
      line_nxt = line_r + 24'd1;
    end
  end

  always_comb begin
    if (nd_r || !dig_r || dot_r > 2'd1) begin
      num_tk = TK_SYMBOL;
    end else if (dot_r == 2'd1) begin
      num_tk = TK_REAL;
    end else begin
      num_tk = TK_INTEGER;
    end
  end

  // byte handled from the idle mode
  always_comb begin
    i_v = 1'b0;
    i_res = '0;
    i_mode = MODE_IDLE;
    i_cnt = '0;
    i_first = first_r;
    i_dig = 1'b0;
    i_sline = sline_r;
    if (is_space(c)) begin
      i_mode = MODE_IDLE;
    end else if (c == CH_SEMI) begin
      i_mode = MODE_COMMENT;
    end else if (c == CH_OPEN) begin
      i_v = 1'b1;
      i_res = mk_end(TK_OPEN);
    end else if (c == CH_CLOSE) begin
      i_v = 1'b1;
      i_res = mk_end(TK_CLOSE);
    end else if (c == CH_QUOTE) begin
      i_sline = line_nxt;
      i_mode = MODE_STRING;
    end else if (c == CH_HASH) begin
      i_mode = MODE_CONST;
    end else begin
      i_v = 1'b1;
      i_res = mk_byte(c);
      i_cnt = LEN_W'(1);
      i_first = c;
      i_dig = is_digit(c);
      i_mode = (is_digit(c) || c == CH_MINUS) ? MODE_NUMBER : MODE_SYMBOL;
    end
  end

  always_comb begin
    if (in_end) begin
      sb = CH_SPACE;
    end else if (mode_r == MODE_ESCAPE && c == CH_LOW_N) begin
      sb = CH_LF;
    end else if (mode_r == MODE_ESCAPE && c == CH_LOW_T) begin
      sb = CH_TAB;
    end else begin
      sb = c;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt = cnt_r;
    sline_nxt = sline_r;
    dig_nxt = dig_r;
    nd_nxt = nd_r;
    dot_nxt = dot_r;
    first_nxt = first_r;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = '0;
    r1 = '0;
    l0 = '0;
    l1 = '0;
    if (!in_end) begin
      case (mode_r)
        MODE_IDLE: begin
          v0 = i_v;
          r0 = i_res;
          mode_nxt = i_mode;
          cnt_nxt = i_cnt;
          first_nxt = i_first;
          dig_nxt = i_dig;
          nd_nxt = 1'b0;
          dot_nxt = 2'd0;
          sline_nxt = i_sline;
        end
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_STRING, MODE_ESCAPE: begin
          if (mode_r == MODE_STRING && c == CH_QUOTE) begin
            v0 = 1'b1;
            r0 = mk_end(TK_STRING);
            l0 = cnt_r;
            mode_nxt = MODE_IDLE;
          end else if (mode_r == MODE_STRING && c == CH_CR) begin
            mode_nxt = MODE_STRING;
          end else if (mode_r == MODE_STRING && c == CH_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            mode_nxt = MODE_STRING;
            if (cnt_r < MAXL) begin
              v0 = 1'b1;
              r0 = mk_byte(sb);
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_r == '0) begin
                first_nxt = sb;
              end
            end
          end
        end
        MODE_CONST: begin
          if (is_word(c)) begin
            if (cnt_r < MAXL) begin
              v0 = 1'b1;
              r0 = mk_byte(c);
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_r == '0) begin
                first_nxt = c;
              end
            end
          end else if (cnt_r == LEN_W'(1) && (first_r == CH_LOW_T || first_r == CH_LOW_F)) begin
            v0 = 1'b1;
            r0 = mk_end((first_r == CH_LOW_T) ? TK_TRUE : TK_FALSE);
            l0 = cnt_r;
            v1 = i_v;
            r1 = i_res;
            mode_nxt = i_mode;
            cnt_nxt = i_cnt;
            first_nxt = i_first;
            dig_nxt = i_dig;
            nd_nxt = 1'b0;
            dot_nxt = 2'd0;
            sline_nxt = i_sline;
          end else begin
            v0 = 1'b1;
            r0 = mk_err(EC_CONST, line_nxt);
            mode_nxt = MODE_ERROR;
          end
        end
        MODE_NUMBER, MODE_SYMBOL: begin
          if (term) begin
            v0 = 1'b1;
            r0 = mk_end((mode_r == MODE_NUMBER) ? num_tk : TK_SYMBOL);
            l0 = cnt_r;
            v1 = i_v;
            r1 = i_res;
            mode_nxt = i_mode;
            cnt_nxt = i_cnt;
            first_nxt = i_first;
            dig_nxt = i_dig;
            nd_nxt = 1'b0;
            dot_nxt = 2'd0;
            sline_nxt = i_sline;
          end else begin
            if (mode_r == MODE_NUMBER) begin
              if (is_digit(c)) begin
                dig_nxt = 1'b1;
              end else if (c == CH_DOT) begin
                if (dot_r < 2'd2) begin
                  dot_nxt = dot_r + 2'd1;
                end
              end else if (is_word(c)) begin
                nd_nxt = 1'b1;
              end
            end
            if (cnt_r < MAXL) begin
              v0 = 1'b1;
              r0 = mk_byte(c);
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_r == '0) begin
                first_nxt = c;
              end
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end else begin
      case (mode_r)
        MODE_IDLE, MODE_COMMENT, MODE_DONE: begin
          v0 = 1'b1;
          r0 = mk_end(TK_EOF);
          mode_nxt = MODE_DONE;
        end
        MODE_STRING, MODE_ESCAPE: begin
          mode_nxt = MODE_ERROR;
          v0 = 1'b1;
          if (cnt_r < MAXL) begin
            r0 = mk_byte(sb);
            v1 = 1'b1;
            r1 = mk_err(EC_STRING, sline_r);
          end else begin
            r0 = mk_err(EC_STRING, sline_r);
          end
        end
        MODE_CONST: begin
          v0 = 1'b1;
          if (cnt_r == LEN_W'(1) && (first_r == CH_LOW_T || first_r == CH_LOW_F)) begin
            r0 = mk_end((first_r == CH_LOW_T) ? TK_TRUE : TK_FALSE);
            l0 = cnt_r;
            v1 = 1'b1;
            r1 = mk_end(TK_EOF);
            mode_nxt = MODE_DONE;
          end else begin
            r0 = mk_err(EC_CONST, line_r);
            mode_nxt = MODE_ERROR;
          end
        end
        MODE_NUMBER, MODE_SYMBOL: begin
          v0 = 1'b1;
          r0 = mk_end((mode_r == MODE_NUMBER) ? num_tk : TK_SYMBOL);
          l0 = cnt_r;
          v1 = 1'b1;
          r1 = mk_end(TK_EOF);
          mode_nxt = MODE_DONE;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  assign push = acc && v0;
  assign push_data = {r0, l0, r1, l1, v1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r <= '0;
      line_r <= '0;
      sline_r <= '0;
      dig_r <= 1'b0;
      nd_r <= 1'b0;
      dot_r <= 2'd0;
      first_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      cnt_r <= cnt_nxt;
      line_r <= line_nxt;
      sline_r <= sline_nxt;
      dig_r <= dig_nxt;
      nd_r <= nd_nxt;
      dot_r <= dot_nxt;
      first_r <= first_nxt;
    end
  end

`ifndef SYNTHESIS
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ERROR) |=> (mode_r == MODE_ERROR))
    else $error("error mode left without reset");
  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ERROR) |-> !push)
    else $error("result produced while halted");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXL)
    else $error("token count beyond limit");
`endif
endmodule
`default_nettype wire

### src/stl_fifo.sv
`default_nettype none
module stl_fifo #(
  parameter int DW = 99
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic [DW-1:0]      pop_data,
  output stl_pkg::fifo_stat_t stat
);
  import stl_pkg::*;

  logic [DW-1:0]        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_r, rptr_r;
  logic [FIFO_AW:0]     count_r;

  assign stat.full = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.full && push) |-> pop)
    else $error("queue overflow");
`endif
endmodule
`default_nettype wire

### src/stl_back.sv
`default_nettype none
module stl_back #(
  parameter int LEN_W = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stl_pkg::fifo_stat_t stat,
  input  wire logic [2*stl_pkg::RES_W+2*LEN_W:0] pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_res_kind,
  output logic [7:0]             out_char_value,
  output logic [3:0]             out_token_kind,
  output logic [LEN_W-1:0]       out_stored_length,
  output logic                   out_error_code,
  output logic [23:0]            out_error_line,
  output logic                   out_last
);
  import stl_pkg::*;

  logic [2*RES_W+2*LEN_W:0] cur_r;
  logic                     cur_v_r, idx_r, done, beat;
  res_t                     r0, r1, sel;
  logic [LEN_W-1:0]         l0, l1;
  logic                     two;

  assign {r0, l0, r1, l1, two} = cur_r;
  assign sel = idx_r ? r1 : r0;

  assign out_valid = cur_v_r;
  assign out_res_kind = sel.kind;
  assign out_char_value = sel.ch;
  assign out_token_kind = sel.tk;
  assign out_stored_length = idx_r ? l1 : l0;
  assign out_error_code = sel.ec;
  assign out_error_line = sel.line;
  assign out_last = idx_r || !two;

  assign beat = cur_v_r && out_ready;
  assign done = beat && out_last;
  assign pop = (!cur_v_r || done) && !stat.empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r <= 1'b0;
    end else if (pop) begin
      cur_v_r <= 1'b1;
      idx_r <= 1'b0;
    end else if (done) begin
      cur_v_r <= 1'b0;
      idx_r <= 1'b0;
    end else if (beat) begin
      idx_r <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_v_r && idx_r) |-> two)
    else $error("second beat of a single-result entry");
`endif
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import stl_pkg::*;

  localparam int MAX_TOK = 1024;
  localparam int LEN_W = $clog2(MAX_TOK + 1);
  localparam int CYCLE_LIMIT = 400000;

  // one expected or observed result beat
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       ch;
    logic [3:0]       tk;
    logic [LEN_W-1:0] len;
    logic             ec;
    logic [23:0]      line;
    logic             last;
  } lex_beat_t;

  // lexer state kept by the predictor
  class lex_scoreboard;
    logic [3:0]  mode;
    int          tok_len;
    logic [23:0] line_cnt;
    logic [23:0] str_line;
    bit          digit_seen, other_seen;
    int          dots;
    logic [7:0]  first_byte;
    lex_beat_t   pending_beats[$];
    int          mismatches;
    int          checked;
    int          tokens_seen[9];
    int          errors_seen;

    function new();
      mode = MODE_IDLE; tok_len = 0; line_cnt = '0; str_line = '0;
      digit_seen = 0; other_seen = 0; dots = 0; first_byte = '0;
      mismatches = 0; checked = 0; errors_seen = 0;
    endfunction

    function void push(logic [1:0] k, logic [7:0] c, logic [3:0] t, int l,
                       logic e, logic [23:0] ln);
      lex_beat_t b;
      b = '0;
      b.kind = k; b.ch = c; b.tk = t; b.len = l[LEN_W-1:0]; b.ec = e; b.line = ln;
      pending_beats.push_back(b);
    endfunction

    function void store_byte(logic [7:0] c);
      if (tok_len < MAX_TOK) begin
        if (tok_len == 0) first_byte = c;
        tok_len++;
        push(RK_BYTE, c, '0, 0, 1'b0, '0);
      end
    endfunction

    // c < 0 means end of file
    function void lex_char(int c);
      logic [7:0] b;
      logic [3:0] t;
      bit again;
      b = c[7:0];
      again = 1;
      while (again) begin
        again = 0;
        case (mode)
          MODE_IDLE: begin
            if (c < 0) begin
              mode = MODE_DONE; push(RK_END, '0, TK_EOF, 0, 1'b0, '0);
            end else if (!is_space(b)) begin
              tok_len = 0; digit_seen = 0; other_seen = 0; dots = 0;
              if (b == CH_SEMI) mode = MODE_COMMENT;
              else if (b == CH_OPEN) push(RK_END, '0, TK_OPEN, 0, 1'b0, '0);
              else if (b == CH_CLOSE) push(RK_END, '0, TK_CLOSE, 0, 1'b0, '0);
              else if (b == CH_QUOTE) begin
                str_line = line_cnt; mode = MODE_STRING;
              end else if (b == CH_HASH) mode = MODE_CONST;
              else begin
                mode = (is_digit(b) || b == CH_MINUS) ? MODE_NUMBER : MODE_SYMBOL;
                again = 1;
              end
            end
          end
          MODE_COMMENT: begin
            if (c < 0) begin
              mode = MODE_IDLE; again = 1;
            end else if (b == CH_LF) mode = MODE_IDLE;
          end
          MODE_STRING: begin
            if (c < 0) begin
              mode = MODE_ERROR; push(RK_ERR, '0, '0, 0, EC_STRING, str_line);
            end else if (b == CH_QUOTE) begin
              mode = MODE_IDLE; push(RK_END, '0, TK_STRING, tok_len, 1'b0, '0);
            end else if (b == CH_BSLASH) mode = MODE_ESCAPE;
            else if (b != CH_CR) store_byte(b);
          end
          MODE_ESCAPE: begin
            if (c < 0) begin
              mode = MODE_ERROR; push(RK_ERR, '0, '0, 0, EC_STRING, str_line);
            end else begin
              if (b == CH_LOW_N) b = CH_LF;
              else if (b == CH_LOW_T) b = CH_TAB;
              mode = MODE_STRING;
              store_byte(b);
            end
          end
          MODE_CONST: begin
            if (c >= 0 && is_word(b)) store_byte(b);
            else if (tok_len == 1 && (first_byte == CH_LOW_T || first_byte == CH_LOW_F)) begin
              push(RK_END, '0, (first_byte == CH_LOW_T) ? TK_TRUE : TK_FALSE, 1, 1'b0, '0);
              mode = MODE_IDLE; again = 1;
            end else begin
              mode = MODE_ERROR; push(RK_ERR, '0, '0, 0, EC_CONST, line_cnt);
            end
          end
          MODE_NUMBER: begin
            if (c < 0 || is_space(b) || is_delim(b)) begin
              if (other_seen || !digit_seen || dots > 1) t = TK_SYMBOL;
              else if (dots == 1) t = TK_REAL;
              else t = TK_INTEGER;
              push(RK_END, '0, t, tok_len, 1'b0, '0);
              mode = MODE_IDLE; again = 1;
            end else begin
              if (is_digit(b)) digit_seen = 1;
              else if (b == CH_DOT) begin
                if (dots < 2) dots++;
              end else if (is_word(b)) other_seen = 1;
              store_byte(b);
            end
          end
          MODE_SYMBOL: begin
            if (c < 0 || is_space(b) || is_delim(b)) begin
              push(RK_END, '0, TK_SYMBOL, tok_len, 1'b0, '0);
              mode = MODE_IDLE; again = 1;
            end else store_byte(b);
          end
          MODE_DONE: begin
            if (c < 0) push(RK_END, '0, TK_EOF, 0, 1'b0, '0);
          end
          default: ;
        endcase
      end
    endfunction

    // note one accepted input beat
    function void note_input(logic [7:0] b, logic eoi);
      int prev_cnt;
      prev_cnt = pending_beats.size();
      if (eoi) begin
        lex_char(CH_SPACE);
        lex_char(-1);
      end else begin
        if (b == CH_LF && mode != MODE_ERROR && line_cnt != LINE_MAX) line_cnt++;
        lex_char(b);
      end
      if (pending_beats.size() > prev_cnt) pending_beats[$].last = 1'b1;
    endfunction

    function void check_result(lex_beat_t got);
      lex_beat_t want;
      checked++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending_beats.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p actual %p", want, got);
      end
      if (want.kind == RK_END) tokens_seen[want.tk]++;
      if (want.kind == RK_ERR) errors_seen++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte = '0;
  logic             in_end_of_input = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_res_kind;
  logic [7:0]       out_char_value;
  logic [3:0]       out_token_kind;
  logic [LEN_W-1:0] out_stored_length;
  logic             out_error_code;
  logic [23:0]      out_error_line;
  logic             out_last;

  sexpr_token_lexer #(.MAX_TOKEN(MAX_TOK)) i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_byte, .in_end_of_input,
    .out_valid, .out_ready, .out_res_kind, .out_char_value, .out_token_kind,
    .out_stored_length, .out_error_code, .out_error_line, .out_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lex_scoreboard sb;
  int send_idle_pct = 22;   // sender gap chance, percent
  int recv_idle_pct = 80;   // receiver stall chance, percent
  int hold_off = 0;         // cycles the receiver still refuses
  int cycles = 0;
  int items_sent = 0;

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_res_kind, out_char_value, out_token_kind, out_stored_length,
                        out_error_code, out_error_line, out_last});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // offer one beat and wait until the block takes it
  task automatic send_beat(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b, eoi);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // stop offering and wait for every expected beat
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // well-formed random token, sometimes with noise
  task automatic send_random_token();
    int n;
    int pick;
    pick = $urandom_range(11);
    n = $urandom_range(1, 6);
    case (pick)
      0: send_beat(CH_OPEN, 1'b0);
      1: send_beat(CH_CLOSE, 1'b0);
      2: begin
        send_beat(CH_QUOTE, 1'b0);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(5))
            0: begin send_beat(CH_BSLASH, 1'b0); send_beat($urandom_range(255), 1'b0); end
            1: send_beat(CH_CR, 1'b0);
            2: send_beat(CH_LF, 1'b0);
            default: send_beat($urandom_range(255), 1'b0);
          endcase
        end
        send_beat(CH_QUOTE, 1'b0);
      end
      // constants always get a space so they do not run into the next token
      3: send_text($urandom_range(1) ? "#t " : "#f ");
      4: for (int i = 0; i < n; i++) send_beat(8'h30 + $urandom_range(9), 1'b0);
      5: begin
        if ($urandom_range(1)) send_beat(CH_MINUS, 1'b0);
        send_beat(8'h30 + $urandom_range(9), 1'b0);
        send_beat(CH_DOT, 1'b0);
        send_beat(8'h30 + $urandom_range(9), 1'b0);
        if ($urandom_range(3) == 0) send_beat(CH_DOT, 1'b0);
      end
      6: for (int i = 0; i < n; i++) send_beat(8'h61 + $urandom_range(25), 1'b0);
      7: begin
        send_beat(CH_SEMI, 1'b0);
        for (int i = 0; i < n; i++) send_beat($urandom_range(255), 1'b0);
        send_beat(CH_LF, 1'b0);
      end
      8: for (int i = 0; i < n; i++) send_beat(8'h80 + $urandom_range(127), 1'b0);
      9: begin
        send_beat(CH_MINUS, 1'b0);
        send_beat($urandom_range(1) ? CH_UNDER : 8'h41 + $urandom_range(25), 1'b0);
      end
      default: send_beat($urandom_range(255), 1'b0);
    endcase
    // separator: whitespace, or nothing so the delimiter rule is exercised
    case ($urandom_range(3))
      0: send_beat(CH_SPACE, 1'b0);
      1: send_beat(CH_LF, 1'b0);
      2: send_beat(8'h09 + $urandom_range(4), 1'b0);
      default: ;
    endcase
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every token type but end of file, escapes, cr drop, extremes of the byte
    send_text("( ) \"a\\n\\t\\\"\015\001\" #t #f 12 -3.5 1.2.3 -x _z ");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text(" ;c\n9");

    // long hold-off while the sender keeps pushing, so the input stalls
    hold_off <= 300;
    for (int i = 0; i < 20; i++) send_beat(8'h61, 1'b0);
    send_beat(CH_SPACE, 1'b0);

    // random phases with three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 22 : 0;
      for (int k = 0; k < 55; k++) send_random_token();
    end

    // comment reaching end of input, then further end marks and ignored bytes
    send_text("; tail");
    send_beat(8'h00, 1'b1);
    send_beat(8'h41, 1'b0);
    send_beat(8'hFF, 1'b1);
    drain();

    $display("sent %0d beats, checked %0d result beats", items_sent, sb.checked);
    $display("tokens per kind: %p, errors %0d", sb.tokens_seen, sb.errors_seen);
    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending_beats.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
